// File: hw/rtl/oaht_pkg.sv
// Shared types and constants of the open-addressing hash table.
package oaht_pkg;

  // Hash and probe constants: home = ((3*key + 7) mod 101) mod size,
  // probe i = home + 5*i + 3*i*i.
  localparam int unsigned HASH_MUL   = 3;
  localparam int unsigned HASH_ADD   = 7;
  localparam int unsigned HASH_MOD   = 101;
  localparam int unsigned PROBE_LIN  = 5;
  localparam int unsigned PROBE_QUAD = 3;

  // Highest shift of the divisor for each reduction; the operand is always
  // below divisor * 2^(shift+1).
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned HASH_SHIFT  = 10;  // 3*65535+7 < 101*2048
  localparam int unsigned HOME_SHIFT  = 6;   // 100 < 1*128
  localparam int unsigned STEP_SHIFT  = 2;   // 6 < 1*8
  localparam int unsigned DELTA_SHIFT = 3;   // 8 < 1*16

  // Narrowest reduction datapath that holds 3*key+7.
  localparam int unsigned REDUCE_MIN_W = 18;

  localparam logic [7:0] CFG_RESET = 8'd128;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  slot;
    logic [31:0] found_value;
  } res_t;

  // One table slot as stored in memory.
  typedef struct packed {
    logic [1:0]  mark;
    logic [15:0] key;
    logic [31:0] value;
  } ent_t;

endpackage

// File: hw/rtl/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oaht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/oaht_reduce.sv
// Shared compare-subtract unit: reduces an operand modulo a divisor,
// one shifted divisor per cycle, from a given shift down to zero.
module oaht_reduce #(
  parameter int unsigned UW = 18,
  parameter int unsigned DW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [UW-1:0]               a_i,
  input  logic [DW-1:0]               div_i,
  input  logic [oaht_pkg::SHIFT_W-1:0] sh_i,
  output logic [UW-1:0]               r_o,
  output logic                        done_o
);

  logic [UW-1:0]                r_q, r_d;
  logic [DW-1:0]                div_q;
  logic [oaht_pkg::SHIFT_W-1:0] k_q;
  logic                         run_q;

  logic [UW-1:0]                cur_r;
  logic [DW-1:0]                cur_div;
  logic [oaht_pkg::SHIFT_W-1:0] cur_k;
  logic [UW-1:0]                sub;

  // One restoring step on either the new operand or the running remainder
  always_comb begin
    cur_r   = load_i ? a_i : r_q;
    cur_div = load_i ? div_i : div_q;
    cur_k   = load_i ? sh_i : k_q;
    sub     = UW'(cur_div) << cur_k;
    r_d     = (cur_r >= sub) ? (cur_r - sub) : cur_r;
  end

  // Run flag, high while shift steps remain; the next block holds the divisor and advances the shift count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (load_i) begin
      run_q <= (sh_i != '0);
    end else if (run_q) begin
      run_q <= (k_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r_q   <= r_d;
      div_q <= div_i;
      k_q   <= sh_i - 1'b1;
    end else if (run_q) begin
      r_q <= r_d;
      k_q <= k_q - 1'b1;
    end
  end

  assign r_o    = r_q;
  assign done_o = !run_q;

endmodule

// File: hw/rtl/open_address_hash_table_top.sv
// Open-addressing hash table with quadratic probing: top level and sequencer.
//
// Each item is an insert, search or delete on a 16-bit key with a 32-bit
// payload. After reset the block sweeps the slot memory to empty, one slot
// per cycle, holding busy high. An item is taken when start is high and
// busy is low. Every reduction modulo 101 or modulo the table size runs on
// one compare-subtract unit, one shifted divisor per cycle: an item first
// forms the home slot and probe step (states HASH, HOME, STEP, DELTA), then
// each probe is a memory read (READ) followed by a check (CHECK), then a
// result state (DONE) raises done_o, and busy drops the cycle after. An
// insert on a full table, a search or delete on an empty one and an unused
// op code go straight from accept to the result state. The result is shown
// for exactly one cycle with done_o high; res_o keeps it until the next item
// is taken. Write table_size only while busy is low.
module open_address_hash_table_top #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  oaht_pkg::req_t       req_i,
  output logic                 done_o,
  output oaht_pkg::res_t       res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_data_i
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  // Divisor width: wide enough for both the table size and 101
  localparam int unsigned MW = $clog2(oaht_pkg::HASH_MOD + 1);
  localparam int unsigned DW = (SW > MW) ? SW : MW;
  localparam int unsigned UW = (SW + 7 > oaht_pkg::REDUCE_MIN_W) ?
                               SW + 7 : oaht_pkg::REDUCE_MIN_W;
  localparam int unsigned EW = $bits(oaht_pkg::ent_t);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_HOME  = 9'b000001000,
    S_STEP  = 9'b000010000,
    S_DELTA = 9'b000100000,
    S_READ  = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  logic [7:0]     cfg_q;
  oaht_pkg::req_t req_q, req_d;
  oaht_pkg::res_t res_q, res_d;
  logic [IW-1:0]  j_q, j_d;
  logic [IW-1:0]  c6_q, c6_d;
  logic [IW-1:0]  d_q, d_d;
  logic [SW-1:0]  i_q, i_d;
  logic [SW-1:0]  occ_q, occ_d;
  logic [IW-1:0]  clr_q, clr_d;

  logic [SW-1:0]  size;
  logic           last_probe;

  logic                         u_load;
  logic [UW-1:0]                u_a;
  logic [DW-1:0]                u_div;
  logic [oaht_pkg::SHIFT_W-1:0] u_sh;
  logic [UW-1:0]                u_r;
  logic                         u_done;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  oaht_pkg::ent_t       ram_wdata;
  logic                 ram_re;
  logic [EW-1:0]        ram_rdata;
  oaht_pkg::ent_t       rd;

  // Clamp the configured size into 1..TABLE_DEPTH
  always_comb begin
    if (cfg_q == '0) begin
      size = SW'(1);
    end else if (32'(cfg_q) > TABLE_DEPTH) begin
      size = SW'(TABLE_DEPTH);
    end else begin
      size = SW'(cfg_q);
    end
  end

  assign last_probe = (i_q == size - 1'b1);
  assign rd         = oaht_pkg::ent_t'(ram_rdata);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    j_d       = j_q;
    c6_d      = c6_q;
    d_d       = d_q;
    i_d       = i_q;
    occ_d     = occ_q;
    clr_d     = clr_q;
    u_load    = 1'b0;
    u_a       = '0;
    u_div     = DW'(size);
    u_sh      = '0;
    ram_we    = 1'b0;
    ram_waddr = j_q;
    ram_wdata = '{mark: oaht_pkg::MARK_EMPTY, key: '0, value: '0};
    ram_re    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // Sweep every slot to empty
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          res_d = '{status: oaht_pkg::ST_MISSING, slot: '0, found_value: '0};
          if (req_i.op == oaht_pkg::OP_INSERT && occ_q >= size) begin
            res_d.status = oaht_pkg::ST_FULL;
            state_d      = S_DONE;
          end else if (req_i.op == oaht_pkg::OP_INSERT ||
                       ((req_i.op == oaht_pkg::OP_SEARCH ||
                         req_i.op == oaht_pkg::OP_DELETE) && occ_q != '0)) begin
            // Start (3*key + 7) mod 101
            u_load  = 1'b1;
            u_a     = UW'(oaht_pkg::HASH_MUL) * UW'(req_i.key) +
                      UW'(oaht_pkg::HASH_ADD);
            u_div   = DW'(oaht_pkg::HASH_MOD);
            u_sh    = oaht_pkg::SHIFT_W'(oaht_pkg::HASH_SHIFT);
            state_d = S_HASH;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_HASH: begin
        if (u_done) begin
          // Reduce the hash modulo the table size
          u_load  = 1'b1;
          u_a     = u_r;
          u_sh    = oaht_pkg::SHIFT_W'(oaht_pkg::HOME_SHIFT);
          state_d = S_HOME;
        end
      end

      S_HOME: begin
        if (u_done) begin
          j_d     = IW'(u_r);
          // Probe step grows by 2*3 each probe, taken modulo size
          u_load  = 1'b1;
          u_a     = UW'(2 * oaht_pkg::PROBE_QUAD);
          u_sh    = oaht_pkg::SHIFT_W'(oaht_pkg::STEP_SHIFT);
          state_d = S_STEP;
        end
      end

      S_STEP: begin
        if (u_done) begin
          c6_d    = IW'(u_r);
          // First step from probe 0 to probe 1 is 5 + 3
          u_load  = 1'b1;
          u_a     = UW'(oaht_pkg::PROBE_LIN + oaht_pkg::PROBE_QUAD);
          u_sh    = oaht_pkg::SHIFT_W'(oaht_pkg::DELTA_SHIFT);
          i_d     = '0;
          state_d = S_DELTA;
        end
      end

      S_DELTA: begin
        if (u_done) begin
          state_d = S_READ;
        end
      end

      S_READ: begin
        // Read the slot; form the next slot while the read is in flight
        ram_re  = 1'b1;
        d_d     = IW'(u_r);
        u_load  = 1'b1;
        u_a     = UW'(j_q) + UW'(IW'(u_r));
        state_d = S_CHECK;
      end

      S_CHECK: begin
        if (req_q.op == oaht_pkg::OP_INSERT) begin
          if (rd.mark != oaht_pkg::MARK_USED) begin
            ram_we       = 1'b1;
            ram_wdata    = '{mark: oaht_pkg::MARK_USED, key: req_q.key,
                             value: req_q.value};
            occ_d        = occ_q + 1'b1;
            res_d.status = oaht_pkg::ST_OK;
            res_d.slot   = 7'(j_q);
            state_d      = S_DONE;
          end else if (last_probe) begin
            res_d.status = oaht_pkg::ST_FULL;
            state_d      = S_DONE;
          end
        end else begin
          if (rd.mark == oaht_pkg::MARK_EMPTY) begin
            state_d = S_DONE;
          end else if (rd.mark == oaht_pkg::MARK_USED && rd.key == req_q.key) begin
            res_d.status      = oaht_pkg::ST_OK;
            res_d.slot        = 7'(j_q);
            res_d.found_value = rd.value;
            if (req_q.op == oaht_pkg::OP_DELETE) begin
              // Leave a tombstone
              ram_we    = 1'b1;
              ram_wdata = '{mark: oaht_pkg::MARK_GONE, key: rd.key, value: rd.value};
              if (occ_q != '0) begin
                occ_d = occ_q - 1'b1;
              end
            end
            state_d = S_DONE;
          end else if (last_probe) begin
            state_d = S_DONE;
          end
        end
        if (state_d == S_CHECK) begin
          // Advance to the next probe and the next step
          j_d     = IW'(u_r);
          u_load  = 1'b1;
          u_a     = UW'(d_q) + UW'(c6_q);
          i_d     = i_q + 1'b1;
          state_d = S_READ;
        end
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      occ_q   <= '0;
      cfg_q   <= oaht_pkg::CFG_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      occ_q   <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    j_q   <= j_d;
    c6_q  <= c6_d;
    d_q   <= d_d;
    i_q   <= i_d;
  end

  oaht_reduce #(
    .UW (UW),
    .DW (DW)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (u_load),
    .a_i    (u_a),
    .div_i  (u_div),
    .sh_i   (u_sh),
    .r_o    (u_r),
    .done_o (u_done)
  );

  oaht_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (j_q),
    .rdata_o (ram_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: hw/rtl/oaht_checker.sv
// Port-level checks of the hash table, bound to the top level.
module oaht_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input oaht_pkg::res_t res_o
);

  // A taken item makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  // A result only appears while an item is in progress
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // After the result the block is free for the next item
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("block still busy after result");

  // Failures carry zero slot and zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != oaht_pkg::ST_OK) |->
      (res_o.slot == '0 && res_o.found_value == '0))
    else $error("failed result with nonzero slot or payload");

endmodule

bind open_address_hash_table_top oaht_checker u_oaht_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

// File: bench/oaht_result_check.sv
// Result checker for the hash table: predicts every response and compares it.
module oaht_result_check #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  oaht_pkg::req_t  req_i,
  input  logic            done_i,
  input  oaht_pkg::res_t  res_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [7:0]      cfg_data_i,
  output int              pending_o,
  output int              error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  // Shadow copy of the slot store, the fill count and the size register
  mark_e       slot_mark_q  [TABLE_DEPTH];
  logic [15:0] slot_key_q   [TABLE_DEPTH];
  logic [31:0] slot_value_q [TABLE_DEPTH];
  int unsigned occupied_q;
  logic [7:0]  table_size_q;

  // Responses still owed by the block, oldest first
  res_t        owed_results [$];
  res_t        want;

  // Clamp the size register to the range the block honors
  function automatic int unsigned active_size();
    if (table_size_q == 8'd0) return 1;
    if (table_size_q > TABLE_DEPTH) return TABLE_DEPTH;
    return table_size_q;
  endfunction

  function automatic int unsigned probe_pos(input int unsigned home, input int unsigned size,
                                            input int unsigned probe);
    return (home + PROBE_LIN * probe + PROBE_QUAD * probe * probe) % size;
  endfunction

  // Apply one request to the shadow table and return the response it earns
  function automatic res_t predict_response(input req_t item);
    int unsigned size;
    int unsigned home;
    int unsigned pos;
    int unsigned key;
    logic        stop;
    res_t        res;
    size = active_size();
    key  = item.key;
    home = ((HASH_MUL * key + HASH_ADD) % HASH_MOD) % size;
    res  = '0;
    res.status = ST_MISSING;
    stop = 1'b0;
    case (item.op)
      OP_INSERT: begin
        res.status = ST_FULL;
        if (occupied_q < size) begin
          for (int unsigned probe = 0; probe < size && !stop; probe++) begin
            pos = probe_pos(home, size, probe);
            if (slot_mark_q[pos] != MARK_USED) begin
              slot_mark_q[pos]  = MARK_USED;
              slot_key_q[pos]   = item.key;
              slot_value_q[pos] = item.value;
              occupied_q++;
              res.status = ST_OK;
              res.slot   = 7'(pos);
              stop = 1'b1;
            end
          end
        end
      end
      OP_SEARCH, OP_DELETE: begin
        if (occupied_q != 0) begin
          for (int unsigned probe = 0; probe < size && !stop; probe++) begin
            pos = probe_pos(home, size, probe);
            if (slot_mark_q[pos] == MARK_EMPTY) begin
              stop = 1'b1;
            end else if (slot_mark_q[pos] == MARK_USED && slot_key_q[pos] == item.key) begin
              res.status      = ST_OK;
              res.slot        = 7'(pos);
              res.found_value = slot_value_q[pos];
              // Leave a tombstone behind a delete
              if (item.op == OP_DELETE) begin
                slot_mark_q[pos] = MARK_GONE;
                occupied_q--;
              end
              stop = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, expected,
               actual);
      error_count_o++;
    end
  endtask

  // Compare results, track size writes, predict each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        slot_mark_q[n]  = MARK_EMPTY;
        slot_key_q[n]   = '0;
        slot_value_q[n] = '0;
      end
      occupied_q   = 0;
      table_size_q = CFG_RESET;
      owed_results.delete();
      pending_o     = 0;
      error_count_o = 0;
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d slot %0d value 0x%0h",
                   $time, res_i.status, res_i.slot, res_i.found_value);
          error_count_o++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", 32'(want.status), 32'(res_i.status));
          check_field("slot", 32'(want.slot), 32'(res_i.slot));
          check_field("found_value", want.found_value, res_i.found_value);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        table_size_q = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(predict_response(req_i));
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// File: bench/open_address_hash_table_top_tb.sv
// Testbench top for the hash table: clock, reset, stimulus and verdict.
module open_address_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 128;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS   = 70;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int          pending;
  int          error_count;
  int unsigned cycles = 0;
  int          burst_left;

  // Keys inserted in the current phase; deleted again at its end
  logic [15:0] phase_keys [$];

  // Table sizes of the random phases, including zero and settings beyond the depth
  logic [7:0]  sweep_sizes [16] = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd13,
                                    8'd16, 8'd37, 8'd64, 8'd101, 8'd127, 8'd128, 8'd255,
                                    8'd200};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  open_address_hash_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  oaht_result_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .res_i        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .error_count_o(error_count)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item, in bursts with random gaps, and hold it until taken
  task automatic send_req(input logic [1:0] item_op, input logic [15:0] item_key,
                          input logic [31:0] item_value);
    int gap;
    if (item_op == OP_INSERT) phase_keys.push_back(item_key);
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= '{op: item_op, key: item_key, value: item_value};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Write the size register once the block has gone idle
  task automatic set_table_size(input logic [7:0] size);
    start <= 1'b0;
    burst_left = 0;
    while (pending != 0 || busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Favor keys already inserted so searches and deletes hit
  function automatic logic [15:0] pick_key(input int reuse_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < reuse_pct && phase_keys.size() != 0) begin
      return phase_keys[$urandom_range(0, phase_keys.size() - 1)];
    end
    if (roll < reuse_pct + 20) return 16'($urandom_range(0, 300));
    return 16'($urandom);
  endfunction

  task automatic send_random(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        send_req(OP_INSERT, pick_key(30), $urandom);
      end else if (roll < 70) begin
        send_req(OP_SEARCH, pick_key(65), $urandom);
      end else if (roll < 95) begin
        send_req(OP_DELETE, pick_key(65), $urandom);
      end else begin
        send_req(OP_UNUSED, 16'($urandom), $urandom);
      end
    end
  endtask

  // Delete every key of the phase at the current table size
  task automatic purge_phase_keys();
    foreach (phase_keys[n]) begin
      send_req(OP_DELETE, phase_keys[n], $urandom);
    end
    phase_keys.delete();
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    burst_left = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, unused op code, extreme keys and values, duplicates
    send_req(OP_SEARCH, 16'h0000, 32'h0000_0000);
    send_req(OP_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 16'h0000, 32'h0000_0000);
    send_req(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 16'h0000, 32'h1234_5678);
    // Same home slot as key 0: probe past it
    send_req(OP_INSERT, 16'd101, 32'hA5A5_A5A5);
    send_req(OP_SEARCH, 16'h0000, 32'h0000_0000);
    send_req(OP_SEARCH, 16'hFFFF, 32'h0000_0000);
    send_req(OP_SEARCH, 16'd202, 32'h0000_0000);
    // Delete one copy, find the other, reuse the tombstone
    send_req(OP_DELETE, 16'h0000, 32'h0000_0000);
    send_req(OP_SEARCH, 16'h0000, 32'h0000_0000);
    send_req(OP_INSERT, 16'd202, 32'h5A5A_5A5A);
    send_req(OP_DELETE, 16'd101, 32'h0000_0000);
    send_req(OP_UNUSED, 16'h0000, 32'h0000_0000);

    // Shrink below the fill count: inserts report a full table
    set_table_size(8'd1);
    send_req(OP_INSERT, 16'd7, 32'h0000_0001);
    send_req(OP_SEARCH, 16'h0000, 32'h0000_0000);
    // Oversized setting acts as the full depth
    set_table_size(8'd255);
    send_req(OP_SEARCH, 16'hFFFF, 32'h0000_0000);
    send_req(OP_DELETE, 16'hFFFF, 32'h0000_0000);
    // Zero acts as one slot
    set_table_size(8'd0);
    send_req(OP_INSERT, 16'd3, 32'h0000_0003);
    send_req(OP_DELETE, 16'h0000, 32'h0000_0000);

    set_table_size(8'd128);
    purge_phase_keys();

    // Random phases over a sweep of table sizes
    foreach (sweep_sizes[p]) begin
      set_table_size(sweep_sizes[p]);
      send_random(PHASE_ITEMS);
      purge_phase_keys();
    end

    // Drop start and let every owed result arrive
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_reduce.sv
hw/rtl/open_address_hash_table_top.sv
hw/rtl/oaht_checker.sv
bench/oaht_result_check.sv
bench/open_address_hash_table_top_tb.sv
